>>> hw/rtl/mscd_pkg.sv
// Shared types, codes and helper functions for the Manchester sync CRC deframer.
package mscd_pkg;

  // Sync word length in bits (4 to 32)
  localparam int SYNC_BITS = 8;
  localparam int SYNC_FILL_W = $clog2(SYNC_BITS + 1);
  localparam int PATTERN_W = 8;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] MIN_LENGTH = 8'd2;
  localparam logic [PATTERN_W-1:0] SYNC_RESET = 8'hCB;

  // Configuration register indexes
  localparam logic CFG_INVERT_POLARITY = 1'b0;
  localparam logic CFG_SYNC_PATTERN = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_DATA = 3'd0;
  localparam logic [2:0] KIND_GOOD = 3'd1;
  localparam logic [2:0] KIND_CRC_ERR = 3'd2;
  localparam logic [2:0] KIND_LEN_ERR = 3'd3;
  localparam logic [2:0] KIND_MAN_ERR = 3'd4;
  localparam logic [2:0] KIND_TRUNC = 3'd5;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic first_chip;
    logic second_chip;
    logic end_of_burst;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] message_type;
    logic [7:0] sequence_number;
    logic [7:0] data_count;
  } out_item_t;

  typedef struct packed {
    logic                 invert_polarity;
    logic [PATTERN_W-1:0] sync_pattern;
  } cfg_t;

  // CRC-8, MSB first, one byte per call
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Sync pattern fitted to SYNC_BITS: truncated or zero-extended
  function automatic logic [SYNC_BITS-1:0] sync_target(input logic [PATTERN_W-1:0] pat);
    logic [SYNC_BITS-1:0] t;
    t = '0;
    for (int i = 0; i < SYNC_BITS; i++) begin
      if (i < PATTERN_W) begin
        t[i] = pat[i % PATTERN_W];
      end
    end
    return t;
  endfunction

endpackage

>>> hw/rtl/mscd_in_if.sv
// Chip-pair request channel: valid/ready handshake with the input fields.
interface mscd_in_if;
  logic valid;
  logic ready;
  logic first_chip;
  logic second_chip;
  logic end_of_burst;

  modport source (output valid, output first_chip, output second_chip,
                  output end_of_burst, input ready);
  modport sink   (input valid, input first_chip, input second_chip,
                  input end_of_burst, output ready);
endinterface

>>> hw/rtl/mscd_out_if.sv
// Result request channel: valid/ready handshake with the result fields.
interface mscd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic [7:0] message_type;
  logic [7:0] sequence_number;
  logic [7:0] data_count;

  modport source (output valid, output kind, output data_byte, output message_type,
                  output sequence_number, output data_count, input ready);
  modport sink   (input valid, input kind, input data_byte, input message_type,
                  input sequence_number, input data_count, output ready);
endinterface

>>> hw/rtl/mscd_framer.sv
// Frame state machine: Manchester decode, sync hunt, byte assembly and CRC check.
module mscd_framer
  import mscd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output logic      res_valid,
  output out_item_t res
);

  phase_t                 phase_r, phase_nxt;
  logic [SYNC_BITS-1:0]   sync_shift_r, sync_shift_nxt;
  logic [SYNC_FILL_W-1:0] sync_fill_r, sync_fill_nxt;
  logic [2:0]             bit_count_r, bit_count_nxt;
  logic [7:0]             acc_r, acc_nxt;
  logic [7:0]             frame_len_r, frame_len_nxt;
  logic [7:0]             byte_idx_r, byte_idx_nxt;
  logic [7:0]             crc_r, crc_nxt;
  logic [7:0]             held_type_r, held_type_nxt;
  logic [7:0]             held_seq_r, held_seq_nxt;

  logic                   chip_a, chip_b, bit_in;
  logic [7:0]             byte_in;
  logic [SYNC_BITS-1:0]   shift_in;
  logic [8:0]             idx_inc;

  assign chip_a   = item.first_chip ^ cfg.invert_polarity;
  assign chip_b   = item.second_chip ^ cfg.invert_polarity;
  assign bit_in   = chip_b;
  assign byte_in  = {acc_r[6:0], bit_in};
  assign shift_in = {sync_shift_r[SYNC_BITS-2:0], bit_in};
  assign idx_inc  = {1'b0, byte_idx_r} + 9'd1;

  always_comb begin
    phase_nxt      = phase_r;
    sync_shift_nxt = sync_shift_r;
    sync_fill_nxt  = sync_fill_r;
    bit_count_nxt  = bit_count_r;
    acc_nxt        = acc_r;
    frame_len_nxt  = frame_len_r;
    byte_idx_nxt   = byte_idx_r;
    crc_nxt        = crc_r;
    held_type_nxt  = held_type_r;
    held_seq_nxt   = held_seq_r;
    res_valid      = 1'b0;
    res            = '0;

    if (step) begin
      if (item.end_of_burst || (chip_a == chip_b)) begin
        // burst end or bad chip pair: abort and hunt again
        res_valid      = (phase_r != PH_HUNT);
        res.kind       = item.end_of_burst ? KIND_TRUNC : KIND_MAN_ERR;
        phase_nxt      = PH_HUNT;
        sync_shift_nxt = '0;
        sync_fill_nxt  = '0;
        bit_count_nxt  = '0;
        acc_nxt        = '0;
      end else if (phase_r == PH_HUNT) begin
        sync_shift_nxt = shift_in;
        if (sync_fill_r != SYNC_FILL_W'(SYNC_BITS)) begin
          sync_fill_nxt = sync_fill_r + 1'b1;
        end
        if ((sync_fill_nxt == SYNC_FILL_W'(SYNC_BITS)) &&
            (shift_in == sync_target(cfg.sync_pattern))) begin
          phase_nxt     = PH_LEN;
          bit_count_nxt = '0;
          acc_nxt       = '0;
          crc_nxt       = '0;
          byte_idx_nxt  = '0;
          frame_len_nxt = '0;
        end
      end else if (bit_count_r != 3'd7) begin
        acc_nxt       = byte_in;
        bit_count_nxt = bit_count_r + 3'd1;
      end else begin
        bit_count_nxt = '0;
        acc_nxt       = '0;
        unique case (phase_r)
          PH_LEN: begin
            if (byte_in < MIN_LENGTH) begin
              res_valid      = 1'b1;
              res.kind       = KIND_LEN_ERR;
              phase_nxt      = PH_HUNT;
              sync_shift_nxt = '0;
              sync_fill_nxt  = '0;
            end else begin
              frame_len_nxt = byte_in;
              crc_nxt       = crc8_update(8'h00, byte_in);
              byte_idx_nxt  = '0;
              phase_nxt     = PH_PAY;
            end
          end
          PH_PAY: begin
            crc_nxt = crc8_update(crc_r, byte_in);
            if (byte_idx_r == 8'd0) begin
              held_type_nxt = byte_in;
            end else if (byte_idx_r == 8'd1) begin
              held_seq_nxt = byte_in;
            end else begin
              res_valid     = 1'b1;
              res.kind      = KIND_DATA;
              res.data_byte = byte_in;
            end
            byte_idx_nxt = idx_inc[7:0];
            if (idx_inc >= {1'b0, frame_len_r}) begin
              phase_nxt = PH_CRC;
            end
          end
          PH_CRC: begin
            res_valid      = 1'b1;
            phase_nxt      = PH_HUNT;
            sync_shift_nxt = '0;
            sync_fill_nxt  = '0;
            if (byte_in == crc_r) begin
              res.kind            = KIND_GOOD;
              res.message_type    = held_type_r;
              res.sequence_number = held_seq_r;
              res.data_count      = frame_len_r - MIN_LENGTH;
            end else begin
              res.kind = KIND_CRC_ERR;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      sync_shift_r <= '0;
      sync_fill_r  <= '0;
      bit_count_r  <= '0;
      acc_r        <= '0;
      frame_len_r  <= '0;
      byte_idx_r   <= '0;
      crc_r        <= '0;
      held_type_r  <= '0;
      held_seq_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      sync_shift_r <= sync_shift_nxt;
      sync_fill_r  <= sync_fill_nxt;
      bit_count_r  <= bit_count_nxt;
      acc_r        <= acc_nxt;
      frame_len_r  <= frame_len_nxt;
      byte_idx_r   <= byte_idx_nxt;
      crc_r        <= crc_nxt;
      held_type_r  <= held_type_nxt;
      held_seq_r   <= held_seq_nxt;
    end
  end

endmodule

>>> hw/rtl/manchester_sync_crc_deframer.sv
// Top level of the Manchester deframer with sync hunt and CRC-8 frame check.
//
// Usage:
//   in_chan  - one request per Manchester chip pair, or an end-of-burst mark
//              (chips ignored then). Valid/ready, taken when both are high.
//   out_chan - zero or one result request per input request: data bytes as
//              they arrive, then one status (good, crc, length, manchester,
//              truncated). Data bytes precede the verdict; drop them on bad
//              status.
//   cfg_*    - write port: index 0 polarity invert, index 1 sync word. Write
//              only while idle.
// Timing:
//   An accepted request lands in the input register, is decoded when the
//   result register is free or draining, and any result is then registered
//   there, driving out_chan.valid. One request per cycle while out_chan.ready
//   stays high; the limit is the single framer update per cycle.
// Reset: synchronous, active low; both registers empty, framer hunting for
//   sync, polarity normal, sync word 0xCB.
// Stall: with out_chan.ready low, the output register holds its result and
//   the input register holds one more request; in_chan.ready then drops.
module manchester_sync_crc_deframer
  import mscd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mscd_in_if.sink              in_chan,
  mscd_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [PATTERN_W-1:0] cfg_data
);

  // configuration registers
  cfg_t      cfg_r;

  // input register stage
  logic      s_valid_r;
  in_item_t  s_item_r;

  // result register stage
  logic      o_valid_r;
  out_item_t o_item_r;

  logic      advance;
  logic      res_valid;
  out_item_t res;

  // the stage moves when the result slot is free or being drained
  assign advance       = s_valid_r && (!o_valid_r || out_chan.ready);
  assign in_chan.ready = !s_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert_polarity <= 1'b0;
      cfg_r.sync_pattern    <= SYNC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INVERT_POLARITY: cfg_r.invert_polarity <= cfg_data[0];
        CFG_SYNC_PATTERN:    cfg_r.sync_pattern    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s_item_r.first_chip   <= in_chan.first_chip;
      s_item_r.second_chip  <= in_chan.second_chip;
      s_item_r.end_of_burst <= in_chan.end_of_burst;
    end
  end

  mscd_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (s_item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      o_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      o_item_r <= res;
    end
  end

  assign out_chan.valid           = o_valid_r;
  assign out_chan.kind            = o_item_r.kind;
  assign out_chan.data_byte       = o_item_r.data_byte;
  assign out_chan.message_type    = o_item_r.message_type;
  assign out_chan.sequence_number = o_item_r.sequence_number;
  assign out_chan.data_count      = o_item_r.data_count;

endmodule
